### rtl/elb_pkg.sv
package elb_pkg;

  // Line store depth by default
  localparam int LINE_MAX_DEF = 64;

  // Channels per packed pixel and their width
  localparam int NCH    = 4;
  localparam int CHAN_W = 8;

  // Coefficient and accumulator fixed point
  localparam int APREC  = 16;
  localparam int ZPREC  = 7;
  localparam int ACC_W  = CHAN_W + ZPREC;
  localparam int DIFF_W = ACC_W + 2;
  localparam int PROD_W = DIFF_W + APREC + 1;
  localparam int STEP_W = PROD_W - APREC;
  localparam int SUM_W  = STEP_W + 1;

  // Depth of the queue between front and back
  localparam int QDEPTH = 2;

  // Reset value of the coefficient
  localparam logic [APREC-1:0] ALPHA_RESET = 16'd44788;

  typedef logic [NCH-1:0][CHAN_W-1:0] pix_t;

  typedef struct packed {
    pix_t pix;
    logic line_end;
  } item_t;

  // Head of the queue as seen by the back part
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

### rtl/elb_ram.sv
module elb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port, and a registered read port that holds when not enabled
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/elb_front.sv
module elb_front
  import elb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output head_t head,
  input  logic  pop
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  item_t          q_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           push;
  logic           do_pop;

  assign in_ready = (cnt_r != QCW'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rp_r];

  // Advance the pointers, wrapping at the queue depth
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QAW'(QDEPTH - 1)) ? '0 : wp_r + QAW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == QAW'(QDEPTH - 1)) ? '0 : rp_r + QAW'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Hold the accepted transaction in the queue
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_item;
    end
  end

endmodule

### rtl/elb_back.sv
module elb_back
  import elb_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF,
  localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1,
  localparam int CW = $clog2(LINE_MAX + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [APREC-1:0] cfg_alpha_gain,
  input  head_t            head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output pix_t             out_pix,
  output logic             out_last
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_ERD  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          n_r, n_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic                   fwd_r, fwd_nxt;
  logic [APREC-1:0]       alpha_r;
  logic [NCH-1:0][ACC_W-1:0] acc_r, acc_nxt;
  logic signed [PROD_W-1:0]  prod_r [NCH];
  logic signed [PROD_W-1:0]  prod_nxt [NCH];
  pix_t                   out_pix_r, out_pix_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   wr_en, rd_en;
  logic [AW-1:0]          wr_addr, rd_addr;
  pix_t                   wr_data, rd_data;
  pix_t                   filt_pix;
  logic [NCH-1:0][ACC_W-1:0] filt_acc;
  logic [CW-1:0]          cnt_inc;
  logic [CW-1:0]          nm1;
  logic [AW-1:0]          last_idx;
  logic [AW-1:0]          slot;
  logic                   out_free;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;
  assign out_last  = out_last_r;

  assign cnt_inc  = (cnt_r < CW'(LINE_MAX)) ? cnt_r + CW'(1) : cnt_r;
  assign slot     = (cnt_r < CW'(LINE_MAX)) ? cnt_r[AW-1:0] : AW'(LINE_MAX - 1);
  assign nm1      = n_r - CW'(1);
  assign last_idx = nm1[AW-1:0];
  assign out_free = !out_valid_r || out_ready;

  elb_ram #(
    .WIDTH ($bits(pix_t)),
    .DEPTH (LINE_MAX)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Multiply each channel's error by the coefficient
  always_comb begin
    logic signed [DIFF_W-1:0] diff;
    for (int c = 0; c < NCH; c++) begin
      diff = $signed({2'b00, rd_data[c], {ZPREC{1'b0}}})
           - $signed({2'b00, acc_r[c]});
      prod_nxt[c] = diff * $signed({1'b0, alpha_r});
    end
  end

  // Accumulate the scaled error, clamp, and form the written-back byte
  always_comb begin
    logic signed [STEP_W-1:0] step;
    logic signed [SUM_W-1:0]  z;
    for (int c = 0; c < NCH; c++) begin
      step = prod_r[c][PROD_W-1:APREC];
      z    = $signed({{(SUM_W-ACC_W){1'b0}}, acc_r[c]}) + $signed({step[STEP_W-1], step});
      if (z[SUM_W-1]) begin
        filt_acc[c] = '0;
      end else if (z[SUM_W-2:ACC_W] != '0) begin
        filt_acc[c] = '1;
      end else begin
        filt_acc[c] = z[ACC_W-1:0];
      end
      filt_pix[c] = filt_acc[c][ACC_W-1:ZPREC];
    end
  end

  // Sequence loading, the two filter passes and the emit
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    fwd_nxt       = fwd_r;
    acc_nxt       = acc_r;
    out_pix_nxt   = out_pix_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pop           = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = slot;
    wr_data       = head.item.pix;
    rd_en         = 1'b0;
    rd_addr       = '0;

    unique case (state_r)
      S_LOAD: begin
        pop   = head.valid;
        wr_en = head.valid;
        if (head.valid) begin
          if (head.item.line_end) begin
            cnt_nxt   = '0;
            n_nxt     = cnt_inc;
            state_nxt = S_RD0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      S_RD0: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        for (int c = 0; c < NCH; c++) begin
          acc_nxt[c] = {rd_data[c], {ZPREC{1'b0}}};
        end
        if (n_r == CW'(1)) begin
          state_nxt = S_ERD;
        end else begin
          idx_nxt   = AW'(1);
          fwd_nxt   = 1'b1;
          rd_en     = 1'b1;
          rd_addr   = AW'(1);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        acc_nxt = filt_acc;
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = filt_pix;
        if (fwd_r && (idx_r == last_idx)) begin
          // Turn round: backward pass starts one below the last pixel
          idx_nxt   = idx_r - AW'(1);
          fwd_nxt   = 1'b0;
          rd_en     = 1'b1;
          rd_addr   = idx_nxt;
          state_nxt = S_MUL;
        end else if (fwd_r) begin
          idx_nxt   = idx_r + AW'(1);
          rd_en     = 1'b1;
          rd_addr   = idx_nxt;
          state_nxt = S_MUL;
        end else if (idx_r == '0) begin
          state_nxt = S_ERD;
        end else begin
          idx_nxt   = idx_r - AW'(1);
          rd_en     = 1'b1;
          rd_addr   = idx_nxt;
          state_nxt = S_MUL;
        end
      end
      S_ERD: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        idx_nxt   = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_pix_nxt   = rd_data;
          out_last_nxt  = (idx_r == last_idx);
          out_valid_nxt = 1'b1;
          if (idx_r == last_idx) begin
            state_nxt = S_LOAD;
          end else begin
            idx_nxt = idx_r + AW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_nxt;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      n_r         <= '0;
      idx_r       <= '0;
      fwd_r       <= 1'b0;
      acc_r       <= '0;
      alpha_r     <= ALPHA_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      fwd_r       <= fwd_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        alpha_r <= cfg_alpha_gain;
      end
    end
  end

  // Payload registers: products and the output pixel
  always_ff @(posedge clk) begin
    for (int c = 0; c < NCH; c++) begin
      prod_r[c] <= prod_nxt[c];
    end
    out_pix_r  <= out_pix_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

### rtl/exponential_line_blur.sv
// Two-pass exponential blur of one line of packed 4-byte pixels. Feed the
// line one pixel per transaction and flag the final pixel with in_line_end;
// the blurred line then comes out in the same order, its final pixel
// flagged with out_last. Each pixel is stored in a single-port-write line
// store of LINE_MAX entries; a longer line keeps overwriting the last entry.
// Pixels are taken one per cycle while the block is loading, and a two-entry
// queue takes up to two more while it filters or emits. After the flagged
// pixel of a line of n stored pixels the filter runs 2*(n-1) steps (the
// product of the error and alpha_gain is registered before the accumulate,
// and each step needs the previous accumulator), then emits one pixel per
// cycle while the receiver is ready. alpha_gain (0.16 fixed point) may
// be rewritten through the cfg_ port only while the block is idle.
module exponential_line_blur
  import elb_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [APREC-1:0] cfg_alpha_gain,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_chan_0,
  input  logic [7:0]       in_chan_1,
  input  logic [7:0]       in_chan_2,
  input  logic [7:0]       in_chan_3,
  input  logic             in_line_end,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_0,
  output logic [7:0]       out_1,
  output logic [7:0]       out_2,
  output logic [7:0]       out_3,
  output logic             out_last
);

  item_t in_item;
  head_t head;
  logic  pop;
  pix_t  out_pix;

  assign in_item.pix      = {in_chan_3, in_chan_2, in_chan_1, in_chan_0};
  assign in_item.line_end = in_line_end;

  elb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  elb_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_alpha_gain (cfg_alpha_gain),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pix        (out_pix),
    .out_last       (out_last)
  );

  assign out_0 = out_pix[0];
  assign out_1 = out_pix[1];
  assign out_2 = out_pix[2];
  assign out_3 = out_pix[3];

endmodule

### tb/tb_exponential_line_blur.sv
module tb_exponential_line_blur;
  timeunit 1ns;
  timeprecision 1ps;

  import elb_pkg::*;

  localparam int LINE_DEPTH = LINE_MAX_DEF;
  localparam int SINK_HOLD  = 400;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE     = 24;
  localparam int PHASE_PIX  = 80;

  typedef enum logic {ROW_PIXEL, ROW_ALPHA} row_kind_t;

  // One directed row: a pixel transaction, or a coefficient write.
  // Bytes of a pixel read from the right: chan_0 is the lowest byte.
  typedef struct {
    row_kind_t        kind;
    pix_t             pix;
    logic             line_end;
    logic [APREC-1:0] alpha;
    bit               typed;
    pix_t             exp_pix;
  } stim_row_t;

  typedef struct {
    pix_t pix;
    logic last;
  } blurred_t;

  localparam int NROWS = 19;

  stim_row_t directed_rows [NROWS] = '{
    '{ROW_PIXEL, 32'h00000000, 1'b1, 16'd0,       1'b1, 32'h00000000},
    '{ROW_PIXEL, 32'hFFFFFFFF, 1'b1, 16'd0,       1'b1, 32'hFFFFFFFF},
    '{ROW_PIXEL, 32'h00FF00FF, 1'b0, 16'd0,       1'b0, 32'h00000000},
    '{ROW_PIXEL, 32'hFF00FF00, 1'b1, 16'd0,       1'b0, 32'h00000000},
    '{ROW_PIXEL, 32'h78563412, 1'b1, 16'd0,       1'b1, 32'h78563412},
    '{ROW_ALPHA, 32'h00000000, 1'b0, 16'd0,       1'b0, 32'h00000000},
    '{ROW_PIXEL, 32'h01FE5AA5, 1'b0, 16'd0,       1'b0, 32'h00000000},
    '{ROW_PIXEL, 32'h7F80FF00, 1'b0, 16'd0,       1'b0, 32'h00000000},
    '{ROW_PIXEL, 32'hCC3300FF, 1'b1, 16'd0,       1'b0, 32'h00000000},
    '{ROW_PIXEL, 32'h80808080, 1'b1, 16'd0,       1'b1, 32'h80808080},
    '{ROW_ALPHA, 32'h00000000, 1'b0, 16'hFFFF,    1'b0, 32'h00000000},
    '{ROW_PIXEL, 32'h00000000, 1'b0, 16'd0,       1'b0, 32'h00000000},
    '{ROW_PIXEL, 32'hFFFFFFFF, 1'b0, 16'd0,       1'b0, 32'h00000000},
    '{ROW_PIXEL, 32'h40302010, 1'b1, 16'd0,       1'b0, 32'h00000000},
    '{ROW_PIXEL, 32'h18813CC3, 1'b1, 16'd0,       1'b1, 32'h18813CC3},
    '{ROW_ALPHA, 32'h00000000, 1'b0, 16'd1,       1'b0, 32'h00000000},
    '{ROW_PIXEL, 32'hFFFFFFFF, 1'b0, 16'd0,       1'b0, 32'h00000000},
    '{ROW_PIXEL, 32'h00000000, 1'b1, 16'd0,       1'b0, 32'h00000000},
    '{ROW_ALPHA, 32'h00000000, 1'b0, ALPHA_RESET, 1'b0, 32'h00000000}
  };

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             cfg_valid      = 1'b0;
  logic             cfg_ready;
  logic [APREC-1:0] cfg_alpha_gain = '0;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  logic [7:0]       in_chan_0      = '0;
  logic [7:0]       in_chan_1      = '0;
  logic [7:0]       in_chan_2      = '0;
  logic [7:0]       in_chan_3      = '0;
  logic             in_line_end    = 1'b0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  logic [7:0]       out_0;
  logic [7:0]       out_1;
  logic [7:0]       out_2;
  logic [7:0]       out_3;
  logic             out_last;

  // Mirror of the block: line store, fill count, accumulators, coefficient
  pix_t             blur_store [LINE_DEPTH];
  int               fill_count = 0;
  int               acc_z [NCH];
  logic [APREC-1:0] alpha_model = ALPHA_RESET;
  blurred_t         blurred_q [$];

  int  errors         = 0;
  int  pixels_sent    = 0;
  int  lines_sent     = 0;
  int  results_seen   = 0;
  int  alpha_writes   = 0;
  int  hold_req_count = 0;
  int  idle_cycles    = 0;
  bit  calm           = 1'b0;

  exponential_line_blur u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_alpha_gain (cfg_alpha_gain),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_chan_0      (in_chan_0),
    .in_chan_1      (in_chan_1),
    .in_chan_2      (in_chan_2),
    .in_chan_3      (in_chan_3),
    .in_line_end    (in_line_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_0          (out_0),
    .out_1          (out_1),
    .out_2          (out_2),
    .out_3          (out_3),
    .out_last       (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One IIR step on a stored pixel: pull each accumulator towards the pixel
  function automatic void smooth_at(int idx);
    longint tgt;
    longint diff;
    longint z;
    for (int c = 0; c < NCH; c++) begin
      tgt  = longint'(blur_store[idx][c]) <<< ZPREC;
      diff = tgt - longint'(acc_z[c]);
      z    = longint'(acc_z[c]) + ((longint'(alpha_model) * diff) >>> APREC);
      if (z < 0) z = 0;
      if (z > 32767) z = 32767;
      acc_z[c] = int'(z);
      blur_store[idx][c] = 8'(z >>> ZPREC);
    end
  endfunction

  // Store a pixel; on the end of the line blur both ways and queue the line
  function automatic void absorb_pixel(pix_t p, logic le);
    int       slot;
    int       n;
    blurred_t r;
    slot = (fill_count < LINE_DEPTH) ? fill_count : LINE_DEPTH - 1;
    blur_store[slot] = p;
    if (fill_count < LINE_DEPTH) fill_count++;
    if (le) begin
      n = fill_count;
      fill_count = 0;
      for (int c = 0; c < NCH; c++) acc_z[c] = int'(blur_store[0][c]) << ZPREC;
      for (int i = 1; i < n; i++) smooth_at(i);
      for (int i = n - 2; i >= 0; i--) smooth_at(i);
      for (int i = 0; i < n; i++) begin
        r.pix  = blur_store[i];
        r.last = (i == n - 1);
        blurred_q.push_back(r);
      end
    end
  endfunction

  function automatic pix_t rand_pixel();
    pix_t p;
    int   r;
    for (int c = 0; c < NCH; c++) begin
      r = $urandom_range(0, 9);
      if (r == 0) p[c] = 8'h00;
      else if (r == 1) p[c] = 8'hFF;
      else p[c] = 8'($urandom_range(0, 255));
    end
    return p;
  endfunction

  // Mostly short lines, now and then a longer one
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return $urandom_range(1, 6);
    else if (r < 18) return $urandom_range(7, 20);
    else return $urandom_range(21, 40);
  endfunction

  task automatic idle_in(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Offer one pixel, hold it until taken, then predict from it
  task automatic send_pixel(pix_t p, logic le);
    in_valid    <= 1'b1;
    in_chan_0   <= p[0];
    in_chan_1   <= p[1];
    in_chan_2   <= p[2];
    in_chan_3   <= p[3];
    in_line_end <= le;
    do @(posedge clk); while (!in_ready);
    absorb_pixel(p, le);
    pixels_sent++;
    if (le) lines_sent++;
  endtask

  task automatic send_line(int len, bit gaps);
    for (int i = 0; i < len; i++) begin
      if (gaps && !calm && $urandom_range(0, 4) == 0) idle_in($urandom_range(1, 14));
      send_pixel(rand_pixel(), i == len - 1);
    end
  endtask

  // Hold the input until every queued result has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk);
  endtask

  // Rewrite the coefficient once the block has gone quiet
  task automatic write_alpha(logic [APREC-1:0] a);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_alpha_gain <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    alpha_model = a;
    alpha_writes++;
  endtask

  // Receiver: random back-pressure, one long hold-off on request
  initial begin
    int served;
    served = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req_count != served) begin
        served = hold_req_count;
        out_ready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    blurred_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (blurred_q.size() == 0) begin
        $display("%0t: unexpected result %h %h %h %h last %b", $realtime,
                 out_0, out_1, out_2, out_3, out_last);
        errors++;
      end else begin
        e = blurred_q.pop_front();
        if (out_0 !== e.pix[0] || out_1 !== e.pix[1] || out_2 !== e.pix[2] ||
            out_3 !== e.pix[3] || out_last !== e.last) begin
          $display("%0t: mismatch expected %h %h %h %h last %b, got %h %h %h %h last %b",
                   $realtime, e.pix[0], e.pix[1], e.pix[2], e.pix[3], e.last,
                   out_0, out_1, out_2, out_3, out_last);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [APREC-1:0] phase_alpha [5];
    int               phase_start;
    blurred_t         typed_res;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: extremes, single-pixel and short lines, coefficient extremes
    for (int i = 0; i < NROWS; i++) begin
      if (directed_rows[i].kind == ROW_ALPHA) begin
        write_alpha(directed_rows[i].alpha);
      end else begin
        if ($urandom_range(0, 2) == 0) idle_in($urandom_range(1, 14));
        send_pixel(directed_rows[i].pix, directed_rows[i].line_end);
        if (directed_rows[i].typed) begin
          typed_res.pix  = directed_rows[i].exp_pix;
          typed_res.last = 1'b1;
          blurred_q[blurred_q.size() - 1] = typed_res;
        end
      end
    end

    // Random phases, each under its own coefficient
    phase_alpha[0] = 16'($urandom_range(0, 65535));
    phase_alpha[1] = 16'hFFFF;
    phase_alpha[2] = 16'd0;
    phase_alpha[3] = 16'($urandom_range(20000, 60000));
    phase_alpha[4] = ALPHA_RESET;
    for (int ph = 0; ph < 5; ph++) begin
      write_alpha(phase_alpha[ph]);
      phase_start = pixels_sent;
      if (ph == 0) send_line(LINE_DEPTH + 6, 1'b1);
      if (ph == 2) send_line(LINE_DEPTH, 1'b1);
      if (ph == 4) calm = 1'b1;
      if (ph == 1) begin
        // Back up the block: long receiver hold while lines keep coming
        hold_req_count++;
        repeat (3) send_line(8, 1'b0);
      end
      while (pixels_sent - phase_start < PHASE_PIX) begin
        send_line(pick_len(), 1'b1);
        if (ph == 3 && pixels_sent - phase_start >= PHASE_PIX / 2 &&
            pixels_sent - phase_start < PHASE_PIX / 2 + 8) begin
          drain();
        end
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (blurred_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, blurred_q.size());
      errors++;
    end

    $display("Blurred %0d lines from %0d pixels, %0d result pixels compared,",
             lines_sent, pixels_sent, results_seen);
    $display("%0d coefficient writes incl. 0 and full scale, overlong and stalled lines",
             alpha_writes);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
